// ===== rtl/ccp_pkg.sv =====
// Shared widths, mode codes and taper tables for the charge current profile.
package ccp_pkg;

    localparam int TAPER_POINTS = 16;
    localparam int SEG_W        = $clog2(TAPER_POINTS);
    localparam int CUR_W        = 14;
    localparam int TICK_W       = 12;
    localparam int PROD_W       = CUR_W + TICK_W;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [2:0] {
        MODE_ABSENT   = 3'd0,
        MODE_EXTREME  = 3'd1,
        MODE_ABNORMAL = 3'd2,
        MODE_PRECH    = 3'd3,
        MODE_CC       = 3'd4,
        MODE_CV       = 3'd5
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TERMINATION = 2'd2;

    localparam logic [TICK_W-1:0] TAPER_TICK [TAPER_POINTS] = '{
        12'd0,    12'd70,   12'd140,  12'd227,  12'd327,  12'd564,  12'd670,  12'd978,
        12'd1340, 12'd1438, 12'd1549, 12'd1657, 12'd1811, 12'd2057, 12'd2548, 12'd2966
    };

    localparam logic [CUR_W-1:0] TAPER_CUR [TAPER_POINTS] = '{
        14'd15000, 14'd13667, 14'd12320, 14'd10980, 14'd9640, 14'd8290, 14'd6955, 14'd5610,
        14'd4550,  14'd3997,  14'd3510,  14'd3194,  14'd3105, 14'd2555, 14'd2179, 14'd2000
    };

    localparam logic [TICK_W-1:0] TAPER_END = TAPER_TICK[TAPER_POINTS-1];

endpackage

// ===== rtl/ccp_div.sv =====
// Restoring divider that produces one quotient bit per cycle for the taper slope.
module ccp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ccp_pkg::PROD_W-1:0]  i_dividend,
    input  logic [ccp_pkg::TICK_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [ccp_pkg::CUR_W-1:0]   o_quotient
);
    import ccp_pkg::*;

    localparam int CNT_W = $clog2(CUR_W + 1);

    logic [TICK_W-1:0] r_rem,  n_rem;
    logic [CUR_W-1:0]  r_dvd,  n_dvd;
    logic [CUR_W-1:0]  r_quo,  n_quo;
    logic [TICK_W-1:0] r_dsr,  n_dsr;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [TICK_W:0]   w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_dvd[CUR_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_comb begin
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_dividend[PROD_W-1:CUR_W];
            n_dvd  = i_dividend[CUR_W-1:0];
            n_dsr  = i_divisor;
            n_cnt  = CNT_W'(CUR_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? TICK_W'(w_trial - {1'b0, r_dsr}) : w_trial[TICK_W-1:0];
            n_dvd = {r_dvd[CUR_W-2:0], 1'b0};
            n_quo = {r_quo[CUR_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/charge_current_profile.sv =====
// Top level of the charge current profile: mode decode, taper sequencer and output register.
//
//   Channel  Direction  Signals                          Contents
//   s        in         i_s_tvalid o_s_tready i_s_tdata  charge_mode
//   m        out        o_m_tvalid i_m_tready o_m_tdata  charge_current, taper_done
//   cfg      in         i_cfg_we i_cfg_idx i_cfg_data    current registers 0 to 2
//
// A word in a mode other than constant voltage, or one that reaches the end of the
// taper, goes from the idle state straight to the hold state. A taper word passes
// through the multiply, the divider start, fourteen divider steps and the handoff
// to the hold state. No new word is accepted until the hold state loads the output.
// Reset is synchronous and clears the tick counter and the registers to defaults.
// A stalled output holds its word while the sequencer waits to load the next one.
module charge_current_profile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [2:0] charge_mode
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [15:0]                     o_m_tdata,   // [13:0] charge_current, [14] taper_done
    input  logic                            i_cfg_we,
    input  logic [ccp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ccp_pkg::CUR_W-1:0]       i_cfg_data
);
    import ccp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_HOLD
    } t_state;

    t_state            r_state;
    logic [CUR_W-1:0]  r_prech, r_normal, r_term;
    logic [TICK_W-1:0] r_ticks;
    logic [CUR_W-1:0]  r_c0;
    logic              r_rise;
    logic [CUR_W-1:0]  r_mag;
    logic [TICK_W-1:0] r_off;
    logic [TICK_W-1:0] r_span;
    logic [PROD_W-1:0] r_prod;
    logic [CUR_W-1:0]  r_res;
    logic              r_res_done;
    logic              r_m_tvalid;
    logic [15:0]       r_m_tdata;

    t_mode             w_mode;
    logic              w_accept;
    logic [TICK_W-1:0] w_next_t;
    logic [SEG_W-1:0]  w_seg;
    logic [SEG_W-1:0]  w_seg_hi;
    logic              w_div_done;
    logic [CUR_W-1:0]  w_quo;
    logic              w_out_free;

    assign w_mode     = t_mode'(i_s_tdata[2:0]);
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_tvalid || i_m_tready;

    always_comb begin
        w_next_t = r_ticks + 1'b1;
        if (w_next_t > TAPER_END) begin
            w_next_t = TAPER_END;
        end
    end

    always_comb begin
        w_seg = '0;
        for (int i = 1; i < TAPER_POINTS - 1; i++) begin
            if (TAPER_TICK[i] <= w_next_t) begin
                w_seg = SEG_W'(i);
            end
        end
        w_seg_hi = w_seg + 1'b1;
    end

    ccp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV_START),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prech    <= CUR_W'(2030);
            r_normal   <= CUR_W'(15000);
            r_term     <= CUR_W'(2000);
            r_ticks    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PRECHARGE:   r_prech  <= i_cfg_data;
                    REG_NORMAL:      r_normal <= i_cfg_data;
                    REG_TERMINATION: r_term   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_m_tvalid && i_m_tready && (r_state != S_HOLD)) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_mode)
                            MODE_EXTREME, MODE_ABNORMAL: begin
                                r_ticks    <= '0;
                                r_res      <= '0;
                                r_res_done <= 1'b0;
                                r_state    <= S_HOLD;
                            end
                            MODE_PRECH: begin
                                r_ticks    <= '0;
                                r_res      <= r_prech;
                                r_res_done <= 1'b0;
                                r_state    <= S_HOLD;
                            end
                            MODE_CC: begin
                                r_ticks    <= '0;
                                r_res      <= r_normal;
                                r_res_done <= 1'b0;
                                r_state    <= S_HOLD;
                            end
                            MODE_CV: begin
                                r_ticks <= w_next_t;
                                if (w_next_t >= TAPER_END) begin
                                    r_res      <= r_term;
                                    r_res_done <= 1'b1;
                                    r_state    <= S_HOLD;
                                end else begin
                                    r_res_done <= 1'b0;
                                    r_c0    <= TAPER_CUR[w_seg];
                                    r_rise  <= TAPER_CUR[w_seg_hi] >= TAPER_CUR[w_seg];
                                    r_mag   <= (TAPER_CUR[w_seg_hi] >= TAPER_CUR[w_seg]) ?
                                               TAPER_CUR[w_seg_hi] - TAPER_CUR[w_seg] :
                                               TAPER_CUR[w_seg] - TAPER_CUR[w_seg_hi];
                                    r_off   <= w_next_t - TAPER_TICK[w_seg];
                                    r_span  <= TAPER_TICK[w_seg_hi] - TAPER_TICK[w_seg];
                                    r_state <= S_MUL;
                                end
                            end
                            default: begin
                                r_res      <= '0;
                                r_res_done <= 1'b0;
                                r_state    <= S_HOLD;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_mag) * PROD_W'(r_off);
                    r_state <= S_DIV_START;
                end
                S_DIV_START: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_res   <= r_rise ? r_c0 + w_quo : r_c0 - w_quo;
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {1'b0, r_res_done, r_res};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

// ===== test/tb_charge_current_profile.sv =====
// Self-checking testbench for the charge current profile: modes, registers, taper sweep, random runs.
module tb_charge_current_profile;
    import ccp_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [CUR_W-1:0] CUR_MAX = '1;
    localparam int KNOTS = 16;
    localparam int LAST_TICK = 2966;
    localparam int KNOT_TICK [KNOTS] = '{
        0, 70, 140, 227, 327, 564, 670, 978,
        1340, 1438, 1549, 1657, 1811, 2057, 2548, 2966
    };
    localparam int KNOT_CUR [KNOTS] = '{
        15000, 13667, 12320, 10980, 9640, 8290, 6955, 5610,
        4550, 3997, 3510, 3194, 3105, 2555, 2179, 2000
    };

    typedef struct packed {
        logic             done;
        logic [CUR_W-1:0] cur;
    } t_current_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata = '0;   // [2:0] charge_mode
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [15:0]          o_m_tdata;        // [13:0] charge_current, [14] taper_done
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CUR_W-1:0]     i_cfg_data = '0;

    logic [TICK_W-1:0] ticks_m = '0;
    logic [CUR_W-1:0]  prech_m = 14'd2030;
    logic [CUR_W-1:0]  normal_m = 14'd15000;
    logic [CUR_W-1:0]  term_m = 14'd2000;

    t_current_word pending_currents [$];
    int unsigned   words_sent = 0;
    int unsigned   words_checked = 0;
    int unsigned   taper_end_words = 0;
    int unsigned   settings_loaded = 0;
    int unsigned   mismatches = 0;
    bit            src_burst = 1'b0;

    charge_current_profile DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 0;
        end
        if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CUR_W-1:0] taper_current(int t);
        int     seg;
        longint c0, c1, span, off;
        seg = 0;
        for (int i = 1; i < KNOTS - 1; i++) begin
            if (KNOT_TICK[i] <= t) begin
                seg = i;
            end
        end
        c0   = KNOT_CUR[seg];
        c1   = KNOT_CUR[seg + 1];
        span = KNOT_TICK[seg + 1] - KNOT_TICK[seg];
        off  = t - KNOT_TICK[seg];
        return CUR_W'(c0 + ((c1 - c0) * off) / span);
    endfunction

    function automatic t_current_word profile_step(logic [2:0] mode);
        t_current_word w;
        w = '0;
        case (mode)
            MODE_EXTREME, MODE_ABNORMAL: begin
                ticks_m = '0;
            end
            MODE_PRECH: begin
                ticks_m = '0;
                w.cur   = prech_m;
            end
            MODE_CC: begin
                ticks_m = '0;
                w.cur   = normal_m;
            end
            MODE_CV: begin
                if (ticks_m < LAST_TICK) begin
                    ticks_m = ticks_m + 1'b1;
                end
                if (ticks_m < LAST_TICK) begin
                    w.cur = taper_current(ticks_m);
                end else begin
                    w.cur  = term_m;
                    w.done = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    task automatic send_mode(logic [2:0] mode);
        int unsigned gap;
        gap = src_burst ? 0 : idle_cycles();
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, mode};
        do @(posedge i_clk); while (!o_s_tready);
        pending_currents.push_back(profile_step(mode));
        words_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CUR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_PRECHARGE:   prech_m = value;
            REG_NORMAL:      normal_m = value;
            REG_TERMINATION: term_m = value;
            default: begin
            end
        endcase
    endtask

    // The write to the unmapped index carries random data and must leave all currents alone.
    task automatic load_currents(logic [CUR_W-1:0] pre, logic [CUR_W-1:0] norm,
                                 logic [CUR_W-1:0] term);
        write_reg(REG_PRECHARGE, pre);
        write_reg(REG_NORMAL, norm);
        write_reg(REG_TERMINATION, term);
        write_reg(REG_UNMAPPED, CUR_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_currents.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_mode_decode();
        logic [2:0] seq [14] = '{
            MODE_CV, MODE_CV, MODE_ABSENT, MODE_SPARE_LO, MODE_SPARE_HI, MODE_CV,
            MODE_PRECH, MODE_CV, MODE_CC, MODE_CV, MODE_EXTREME, MODE_CV,
            MODE_ABNORMAL, MODE_CV
        };
        foreach (seq[i]) begin
            send_mode(seq[i]);
        end
    endtask

    task automatic test_register_extremes();
        drain();
        load_currents(CUR_MAX, CUR_MAX, CUR_MAX);
        send_mode(MODE_PRECH);
        send_mode(MODE_CC);
        drain();
        load_currents('0, '0, '0);
        send_mode(MODE_PRECH);
        send_mode(MODE_CC);
    endtask

    // Walks every taper segment, then holds the counter at its ceiling across a register change.
    task automatic test_full_taper();
        drain();
        load_currents('0, CUR_MAX, CUR_MAX);
        send_mode(MODE_CC);
        repeat (LAST_TICK + 4) send_mode(MODE_CV);
        drain();
        load_currents(CUR_MAX, '0, '0);
        repeat (3) send_mode(MODE_CV);
    endtask

    task automatic test_random_runs();
        int unsigned budget, run_len;
        logic [2:0]  mode;
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            load_currents(CUR_W'($urandom), CUR_W'($urandom), CUR_W'($urandom));
            budget = 0;
            while (budget < 60) begin
                src_burst = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 99) < 55) begin
                    run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                           : $urandom_range(1, 40);
                    repeat (run_len) send_mode(MODE_CV);
                    budget += run_len;
                end else begin
                    mode = 3'($urandom_range(0, 7));
                    if (mode == MODE_CV) begin
                        mode = MODE_ABSENT;
                    end
                    send_mode(mode);
                    budget++;
                end
            end
        end
        src_burst = 1'b0;
    endtask

    initial begin : sink_stalls
        int unsigned span;
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                span = $urandom_range(50, 300);
                repeat (span) begin
                    @(negedge i_clk);
                    i_m_tready <= 1'b1;
                end
            end else begin
                span = 1 + idle_cycles();
                repeat (span) begin
                    @(negedge i_clk);
                    i_m_tready <= 1'b0;
                end
                span = $urandom_range(1, 4);
                repeat (span) begin
                    @(negedge i_clk);
                    i_m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        t_current_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_currents.size() == 0) begin
                $error("Unexpected current word %h", o_m_tdata);
                mismatches++;
            end else begin
                want = pending_currents.pop_front();
                words_checked++;
                if (want.done) begin
                    taper_end_words++;
                end
                if (o_m_tdata[CUR_W-1:0] !== want.cur) begin
                    $error("charge_current: expected %0d, got %0d",
                           want.cur, o_m_tdata[CUR_W-1:0]);
                    mismatches++;
                end
                if (o_m_tdata[CUR_W] !== want.done) begin
                    $error("taper_done: expected %0b, got %0b", want.done, o_m_tdata[CUR_W]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_mode_decode();
        test_register_extremes();
        test_full_taper();
        test_random_runs();
        drain();
        repeat (40) @(posedge i_clk);
        if (pending_currents.size() != 0) begin
            $error("%0d current words never arrived", pending_currents.size());
            mismatches++;
        end
        $display("Sent %0d mode words under %0d register settings; checked %0d current words.",
                 words_sent, settings_loaded, words_checked);
        $display("%0d of them came from the end of the taper; %0d mismatches.",
                 taper_end_words, mismatches);
        if (mismatches == 0) begin
            $display("charge_current_profile regression: pass");
        end else begin
            $display("charge_current_profile regression: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("charge_current_profile regression: fail");
        $finish;
    end

endmodule
